[sv/dvru_pkg.sv]
// Shared types and constants for the distance-vector route update block.
`default_nettype none
package dvru_pkg;

   localparam int MetricW = 10;
   localparam int NicW    = 3;
   localparam int IdxW    = 6;
   localparam int CfgW    = 4;
   localparam int IdxCodes = 2 ** IdxW;

   localparam logic [MetricW-1:0] UNREACH  = 10'd1000;
   localparam logic [CfgW-1:0]    NICS_RST = 4'd8;

   typedef enum logic {
      OP_INSTALL = 1'b0,
      OP_UPDATE  = 1'b1
   } op_type;

   // classified command, as held in the queue
   typedef struct packed {
      op_type               op;
      logic [NicW-1:0]      nic;
      logic                 nic_ok;       // nic addresses a real interface
      logic [MetricW-1:0]   metric;       // as reported
      logic [MetricW-1:0]   inst_metric;  // metric + 1, saturated
   } cmd_type;

endpackage
`default_nettype wire

[sv/dvru_front.sv]
// Front end: folds the route index into range and classifies each item.
`default_nettype none
module dvru_front #(
   parameter int ROUTES = 64,
   parameter int NICS   = 8
) (
   input  wire logic                           req_op,
   input  wire logic [dvru_pkg::IdxW-1:0]      req_route_index,
   input  wire logic [dvru_pkg::NicW-1:0]      req_nic,
   input  wire logic [dvru_pkg::MetricW-1:0]   req_metric,
   output      logic [$clog2(ROUTES)-1:0]      route,
   output      dvru_pkg::cmd_type              cmd
);

   localparam int RW  = $clog2(ROUTES);
   localparam int NIW = $clog2(NICS);
   localparam int NW  = (NIW > dvru_pkg::NicW) ? NIW : dvru_pkg::NicW;
   localparam int NCW = NW + 1;

   // index modulo ROUTES, constant table
   logic [RW-1:0] mod_tab [dvru_pkg::IdxCodes];

   for (genvar g = 0; g < dvru_pkg::IdxCodes; g++) begin : g_mod
      assign mod_tab[g] = RW'(g % ROUTES);
   end

   assign route = mod_tab[req_route_index];

   always_comb begin
      cmd.op     = dvru_pkg::op_type'(req_op);
      cmd.nic    = req_nic;
      cmd.nic_ok = (NCW'(req_nic) < NCW'(NICS));
      cmd.metric = req_metric;
      if (req_metric >= dvru_pkg::UNREACH) begin
         cmd.inst_metric = dvru_pkg::UNREACH;
      end else begin
         cmd.inst_metric = req_metric + dvru_pkg::MetricW'(1);
      end
   end

endmodule
`default_nettype wire

[sv/dvru_queue.sv]
// Short FIFO decoupling the front end from the sequencer.
`default_nettype none
module dvru_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output      logic             push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output      logic             pop_valid,
   input  wire logic             pop_ready,
   output      logic [WIDTH-1:0] pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

[sv/dvru_back.sv]
// Sequencer: owns the route tables, runs installs and metric scans.
`default_nettype none
module dvru_back #(
   parameter int ROUTES = 64,
   parameter int NICS   = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           q_valid,
   output      logic                           q_pop,
   input  wire logic [$clog2(ROUTES)-1:0]      q_route,
   input  wire dvru_pkg::cmd_type              q_cmd,
   input  wire logic [$clog2(NICS+1)-1:0]      act_nics,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      logic                           rsp_changed,
   output      logic [dvru_pkg::NicW-1:0]      rsp_best_nic,
   output      logic [dvru_pkg::MetricW-1:0]   rsp_best_metric
);

   localparam int RW  = $clog2(ROUTES);
   localparam int NIW = $clog2(NICS);
   localparam int NW  = (NIW > dvru_pkg::NicW) ? NIW : dvru_pkg::NicW;
   localparam int NCW = NW + 1;
   localparam int CW  = $clog2(NICS + 1);
   localparam int AW  = $clog2(ROUTES * NICS);
   localparam int MW  = dvru_pkg::MetricW;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_SWEEP   = 7'b0000010,
      ST_WRITE   = 7'b0000100,
      ST_SCAN    = 7'b0001000,
      ST_DRAIN   = 7'b0010000,
      ST_RESOLVE = 7'b0100000,
      ST_FINISH  = 7'b1000000
   } state_type;

   // storage
   logic [MW-1:0] nm_mem [ROUTES * NICS];
   logic [MW-1:0] rm_mem [ROUTES];
   logic [NW-1:0] rn_mem [ROUTES];
   logic [MW-1:0] nm_rd_ff;
   logic [MW-1:0] rm_rd_ff;
   logic [NW-1:0] rn_rd_ff;

   state_type         state_ff, state_in;
   dvru_pkg::cmd_type cmd_ff, cmd_in;
   logic [RW-1:0]     route_ff, route_in;
   logic [AW-1:0]     base_ff, base_in;
   logic [NIW-1:0]    j_ff, j_in;
   logic              cmp_en_ff, cmp_en_in;
   logic [NIW-1:0]    rd_j_ff, rd_j_in;
   logic              first_ff, first_in;
   logic [MW-1:0]     best_ff, best_in;
   logic [NIW-1:0]    best_j_ff, best_j_in;
   logic              res_changed_ff, res_changed_in;
   logic [NW-1:0]     res_nic_ff, res_nic_in;
   logic [MW-1:0]     res_metric_ff, res_metric_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_changed_ff, rsp_changed_in;
   logic [dvru_pkg::NicW-1:0] rsp_nic_ff, rsp_nic_in;
   logic [MW-1:0]     rsp_metric_ff, rsp_metric_in;

   logic          nm_we, nm_re;
   logic [AW-1:0] nm_waddr, nm_raddr;
   logic [MW-1:0] nm_wdata;
   logic          rt_we, rt_re;
   logic [MW-1:0] relaxed_metric;
   logic          scan_last;

   assign relaxed_metric = (best_ff < dvru_pkg::UNREACH) ? best_ff + MW'(1)
                                                         : dvru_pkg::UNREACH;
   assign scan_last  = ((CW'(j_ff) + CW'(1)) == act_nics);

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      route_in       = route_ff;
      base_in        = base_ff;
      j_in           = j_ff;
      cmp_en_in      = 1'b0;
      rd_j_in        = rd_j_ff;
      first_in       = first_ff;
      best_in        = best_ff;
      best_j_in      = best_j_ff;
      res_changed_in = res_changed_ff;
      res_nic_in     = res_nic_ff;
      res_metric_in  = res_metric_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_changed_in = rsp_changed_ff;
      rsp_nic_in     = rsp_nic_ff;
      rsp_metric_in  = rsp_metric_ff;
      q_pop          = 1'b0;
      nm_we          = 1'b0;
      nm_re          = 1'b0;
      nm_waddr       = base_ff + AW'(j_ff);
      nm_raddr       = base_ff + AW'(j_ff);
      nm_wdata       = dvru_pkg::UNREACH;
      rt_we          = 1'b0;
      rt_re          = 1'b0;

      // running minimum over returned reads, first strict minimum wins
      if (cmp_en_ff) begin
         if (first_ff || (nm_rd_ff < best_ff)) begin
            best_in   = nm_rd_ff;
            best_j_in = rd_j_ff;
         end
         first_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_cmd;
               route_in = q_route;
               base_in  = AW'(q_route) * AW'(NICS);
               j_in     = '0;
               first_in = 1'b1;
               if (q_cmd.op == dvru_pkg::OP_INSTALL) begin
                  state_in = ST_SWEEP;
               end else begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_SWEEP: begin
            nm_we = 1'b1;
            if (cmd_ff.nic_ok && (NCW'(cmd_ff.nic) == NCW'(j_ff))) begin
               nm_wdata = cmd_ff.metric;
            end
            rt_we          = 1'b1;
            res_changed_in = 1'b1;
            res_nic_in     = NW'(cmd_ff.nic);
            res_metric_in  = cmd_ff.inst_metric;
            if (j_ff == NIW'(NICS - 1)) begin
               state_in = ST_FINISH;
            end else begin
               j_in = j_ff + NIW'(1);
            end
         end
         ST_WRITE: begin
            nm_we    = cmd_ff.nic_ok;
            nm_waddr = base_ff + AW'(NIW'(cmd_ff.nic));
            nm_wdata = cmd_ff.metric;
            rt_re    = 1'b1;
            j_in     = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            nm_re     = 1'b1;
            cmp_en_in = 1'b1;
            rd_j_in   = j_ff;
            if (scan_last) begin
               state_in = ST_DRAIN;
            end else begin
               j_in = j_ff + NIW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESOLVE;
         end
         ST_RESOLVE: begin
            rt_we          = 1'b1;
            res_changed_in = !((rm_rd_ff == relaxed_metric) &&
                               (rn_rd_ff == NW'(best_j_ff)));
            res_nic_in     = NW'(best_j_ff);
            res_metric_in  = relaxed_metric;
            state_in       = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_changed_in = res_changed_ff;
               rsp_nic_in     = dvru_pkg::NicW'(res_nic_ff);
               rsp_metric_in  = res_metric_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_en_ff    <= cmp_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      route_ff       <= route_in;
      base_ff        <= base_in;
      j_ff           <= j_in;
      rd_j_ff        <= rd_j_in;
      first_ff       <= first_in;
      best_ff        <= best_in;
      best_j_ff      <= best_j_in;
      res_changed_ff <= res_changed_in;
      res_nic_ff     <= res_nic_in;
      res_metric_ff  <= res_metric_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_nic_ff     <= rsp_nic_in;
      rsp_metric_ff  <= rsp_metric_in;
   end

   // neighbour metric store
   always_ff @(posedge clock) begin
      if (nm_we) begin
         nm_mem[nm_waddr] <= nm_wdata;
      end
      if (nm_re) begin
         nm_rd_ff <= nm_mem[nm_raddr];
      end
   end

   // route metric and interface store
   always_ff @(posedge clock) begin
      if (rt_we) begin
         rm_mem[route_ff] <= res_metric_in;
         rn_mem[route_ff] <= res_nic_in;
      end
      if (rt_re) begin
         rm_rd_ff <= rm_mem[route_ff];
         rn_rd_ff <= rn_mem[route_ff];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_changed     = rsp_changed_ff;
   assign rsp_best_nic    = rsp_nic_ff;
   assign rsp_best_metric = rsp_metric_ff;

   a_metric_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_metric_ff <= dvru_pkg::UNREACH))
      else $error("route metric above unreachable");

   a_load_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result loaded outside finish");

   a_install_changes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && !res_changed_ff) |-> (cmd_ff.op == dvru_pkg::OP_UPDATE))
      else $error("install reported unchanged");

   a_cmp_after_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_en_ff |-> $past(state_ff == ST_SCAN))
      else $error("compare without a scan read");

endmodule
`default_nettype wire

[sv/distance_vector_route_update.sv]
// Top level of the distance-vector route update block.
//
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  req      | req_valid/ready, op, route_index, nic,  | in
//           | metric                                  |
//  rsp      | rsp_valid/ready, changed, best_nic,     | out
//           | best_metric                             |
//  csr      | csr_we, csr_wdata (nics_in_use)         | in
//
// Install item: the sequencer sweeps the neighbour metric row, one write per cycle.
// Update item: the sequencer scans the n interfaces in use, one registered memory
//   read per scanned interface, then resolves the new route.
// Reset clears control state only; the tables need no clearing pass.
// A two-item queue lets req keep accepting while the sequencer works, and the
//   result register lets the sequencer finish an item while rsp is stalled.
`default_nettype none
module distance_vector_route_update #(
   parameter int ROUTES = 64,
   parameter int NICS   = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire logic                           req_op,
   input  wire logic [dvru_pkg::IdxW-1:0]      req_route_index,
   input  wire logic [dvru_pkg::NicW-1:0]      req_nic,
   input  wire logic [dvru_pkg::MetricW-1:0]   req_metric,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      logic                           rsp_changed,
   output      logic [dvru_pkg::NicW-1:0]      rsp_best_nic,
   output      logic [dvru_pkg::MetricW-1:0]   rsp_best_metric,
   input  wire logic                           csr_we,
   input  wire logic [dvru_pkg::CfgW-1:0]      csr_wdata
);

   localparam int RW    = $clog2(ROUTES);
   localparam int CW    = $clog2(NICS + 1);
   localparam int XW    = (CW > dvru_pkg::CfgW) ? CW : dvru_pkg::CfgW;
   localparam int QW    = RW + $bits(dvru_pkg::cmd_type);
   localparam int QDEPTH = 2;

   // interfaces-in-use register, clamped to 1..NICS
   logic [dvru_pkg::CfgW-1:0] nics_ff, nics_in;
   logic [XW-1:0]             nics_x;
   logic [CW-1:0]             act_nics;

   assign nics_in = csr_we ? csr_wdata : nics_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         nics_ff <= dvru_pkg::NICS_RST;
      end else begin
         nics_ff <= nics_in;
      end
   end

   always_comb begin
      if (nics_ff == '0) begin
         nics_x = XW'(1);
      end else if (XW'(nics_ff) > XW'(NICS)) begin
         nics_x = XW'(NICS);
      end else begin
         nics_x = XW'(nics_ff);
      end
   end

   assign act_nics = CW'(nics_x);

   // front end: classify
   logic [RW-1:0]     f_route;
   dvru_pkg::cmd_type f_cmd;

   dvru_front #(
      .ROUTES (ROUTES),
      .NICS   (NICS)
   ) u_front (
      .req_op          (req_op),
      .req_route_index (req_route_index),
      .req_nic         (req_nic),
      .req_metric      (req_metric),
      .route           (f_route),
      .cmd             (f_cmd)
   );

   // queue between front and sequencer
   logic          q_valid, q_pop;
   logic [QW-1:0] q_data;
   logic [RW-1:0] q_route;
   dvru_pkg::cmd_type q_cmd;

   dvru_queue #(
      .WIDTH (QW),
      .DEPTH (QDEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_data  ({f_route, f_cmd}),
      .pop_valid  (q_valid),
      .pop_ready  (q_pop),
      .pop_data   (q_data)
   );

   assign q_route = q_data[QW-1 -: RW];
   assign q_cmd   = dvru_pkg::cmd_type'(q_data[QW-RW-1:0]);

   // sequencer and tables
   dvru_back #(
      .ROUTES (ROUTES),
      .NICS   (NICS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_pop           (q_pop),
      .q_route         (q_route),
      .q_cmd           (q_cmd),
      .act_nics        (act_nics),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_changed     (rsp_changed),
      .rsp_best_nic    (rsp_best_nic),
      .rsp_best_metric (rsp_best_metric)
   );

endmodule
`default_nettype wire

[tb/dvru_route_checker.sv]
// Route table predictor and result checker for the distance-vector route update block.
`timescale 1ns / 1ps
module dvru_route_checker #(
   parameter int ROUTES = 64,
   parameter int NICS   = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_ready,
   input  wire logic                           req_op,
   input  wire logic [dvru_pkg::IdxW-1:0]      req_route_index,
   input  wire logic [dvru_pkg::NicW-1:0]      req_nic,
   input  wire logic [dvru_pkg::MetricW-1:0]   req_metric,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   input  wire logic                           rsp_changed,
   input  wire logic [dvru_pkg::NicW-1:0]      rsp_best_nic,
   input  wire logic [dvru_pkg::MetricW-1:0]   rsp_best_metric,
   input  wire logic                           csr_we,
   input  wire logic [dvru_pkg::CfgW-1:0]      csr_wdata,
   output int                                  fail_count,
   output int                                  results_due
);

   typedef struct packed {
      logic                         changed;
      logic [dvru_pkg::NicW-1:0]    best_nic;
      logic [dvru_pkg::MetricW-1:0] best_metric;
   } route_result_type;

   // shadow of the route table
   logic [dvru_pkg::MetricW-1:0] nbr_metric [ROUTES][NICS];
   logic [dvru_pkg::MetricW-1:0] route_metric_tab [ROUTES];
   logic [dvru_pkg::NicW-1:0]    route_nic_tab [ROUTES];
   logic [dvru_pkg::CfgW-1:0]    scan_width;

   route_result_type due_results [$];
   int fail_tally;

   function automatic route_result_type relax_route(input dvru_pkg::op_type op,
         input logic [dvru_pkg::IdxW-1:0] idx, input logic [dvru_pkg::NicW-1:0] nic,
         input logic [dvru_pkg::MetricW-1:0] metric);
      route_result_type res;
      int r;
      int scan;
      int best;
      int best_j;
      logic [dvru_pkg::MetricW:0] next_m;
      r = int'(idx) % ROUTES;
      scan = (scan_width == 0) ? 1 : ((int'(scan_width) > NICS) ? NICS : int'(scan_width));
      res.changed = 1'b1;
      if (op == dvru_pkg::OP_INSTALL) begin
         for (int j = 0; j < NICS; j++) nbr_metric[r][j] = dvru_pkg::UNREACH;
         if (int'(nic) < NICS) nbr_metric[r][nic] = metric;
         next_m = {1'b0, metric} + 1'b1;
         if (next_m > {1'b0, dvru_pkg::UNREACH}) next_m = {1'b0, dvru_pkg::UNREACH};
         route_metric_tab[r] = next_m[dvru_pkg::MetricW-1:0];
         route_nic_tab[r]    = nic;
      end else begin
         if (int'(nic) < NICS) nbr_metric[r][nic] = metric;
         best   = 32'h7fff_ffff;
         best_j = 0;
         // first strict minimum wins ties
         for (int j = 0; j < scan; j++) begin
            if (int'(nbr_metric[r][j]) < best) begin
               best   = int'(nbr_metric[r][j]);
               best_j = j;
            end
         end
         next_m = (best < int'(dvru_pkg::UNREACH)) ? (dvru_pkg::MetricW+1)'(best + 1)
                                                   : {1'b0, dvru_pkg::UNREACH};
         if (route_metric_tab[r] == next_m[dvru_pkg::MetricW-1:0] &&
             int'(route_nic_tab[r]) == best_j)
            res.changed = 1'b0;
         else begin
            route_metric_tab[r] = next_m[dvru_pkg::MetricW-1:0];
            route_nic_tab[r]    = dvru_pkg::NicW'(best_j);
         end
      end
      res.best_nic    = route_nic_tab[r];
      res.best_metric = route_metric_tab[r];
      return res;
   endfunction

   always @(posedge clock) begin
      route_result_type want;
      if (reset) begin
         for (int r = 0; r < ROUTES; r++) begin
            for (int j = 0; j < NICS; j++) nbr_metric[r][j] = '0;
            route_metric_tab[r] = '0;
            route_nic_tab[r]    = '0;
         end
         scan_width = dvru_pkg::NICS_RST;
         due_results.delete();
         fail_tally = 0;
      end else begin
         // pop before push: a result never belongs to the item taken on the same edge
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               $error("result with nothing expected: changed %0d best_nic %0d best_metric %0d",
                      rsp_changed, rsp_best_nic, rsp_best_metric);
               fail_tally++;
            end else begin
               want = due_results.pop_front();
               if (rsp_changed !== want.changed) begin
                  $error("changed: expected %0d, actual %0d", want.changed, rsp_changed);
                  fail_tally++;
               end
               if (rsp_best_nic !== want.best_nic) begin
                  $error("best_nic: expected %0d, actual %0d", want.best_nic, rsp_best_nic);
                  fail_tally++;
               end
               if (rsp_best_metric !== want.best_metric) begin
                  $error("best_metric: expected %0d, actual %0d",
                         want.best_metric, rsp_best_metric);
                  fail_tally++;
               end
            end
         end
         if (csr_we) scan_width = csr_wdata;
         if (req_valid && req_ready)
            due_results.push_back(relax_route(dvru_pkg::op_type'(req_op), req_route_index,
                                              req_nic, req_metric));
      end
      fail_count  <= fail_tally;
      results_due <= due_results.size();
   end

endmodule

[tb/tb_distance_vector_route_update.sv]
// Testbench top: stimulus, receiver pacing, watchdog and verdict for the route update block.
`timescale 1ns / 1ps
module tb_distance_vector_route_update;

   localparam int ROUTES      = 64;
   localparam int NICS        = 8;
   localparam int PHASE_ITEMS = 250;
   localparam int HOLD_CYCLES = 600;   // long receiver hold-off
   // no-accept limit: hold-off plus the longest sender gap and a full item, several times over
   localparam int STALL_LIMIT = 5000;

   typedef enum int {
      RX_ALWAYS,
      RX_COIN,
      RX_PATTERN
   } rx_mode_type;

   // every input is known from time zero
   logic                         clock           = 1'b0;
   logic                         reset           = 1'b1;
   logic                         req_valid       = 1'b0;
   logic                         req_op          = 1'b0;
   logic [dvru_pkg::IdxW-1:0]    req_route_index = '0;
   logic [dvru_pkg::NicW-1:0]    req_nic         = '0;
   logic [dvru_pkg::MetricW-1:0] req_metric      = '0;
   logic                         rsp_ready       = 1'b0;
   logic                         csr_we          = 1'b0;
   logic [dvru_pkg::CfgW-1:0]    csr_wdata       = '0;

   wire logic                         req_ready;
   wire logic                         rsp_valid;
   wire logic                         rsp_changed;
   wire logic [dvru_pkg::NicW-1:0]    rsp_best_nic;
   wire logic [dvru_pkg::MetricW-1:0] rsp_best_metric;

   int fail_count;
   int results_due;

   // run statistics
   int installs;
   int updates;
   int cfg_writes;
   int results_taken = 0;
   int long_holds    = 0;
   int idle_cycles   = 0;
   int burst_left;

   // routes that have been seeded; updates go only to these
   bit installed [ROUTES];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   distance_vector_route_update dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_route_index (req_route_index),
      .req_nic         (req_nic),
      .req_metric      (req_metric),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_changed     (rsp_changed),
      .rsp_best_nic    (rsp_best_nic),
      .rsp_best_metric (rsp_best_metric),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   dvru_route_checker #(.ROUTES(ROUTES), .NICS(NICS)) route_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_route_index (req_route_index),
      .req_nic         (req_nic),
      .req_metric      (req_metric),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_changed     (rsp_changed),
      .rsp_best_nic    (rsp_best_nic),
      .rsp_best_metric (rsp_best_metric),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .results_due     (results_due)
   );

   // Watchdog: any handshake on either channel counts as progress.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no item accepted for %0d cycles", idle_cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Offer one item and hold it until taken. Valid stays high on return so a
   // following item goes out back to back.
   task automatic send_item(input dvru_pkg::op_type op,
         input logic [dvru_pkg::IdxW-1:0] idx,
         input logic [dvru_pkg::NicW-1:0] nic,
         input logic [dvru_pkg::MetricW-1:0] metric);
      req_valid       <= 1'b1;
      req_op          <= op;
      req_route_index <= idx;
      req_nic         <= nic;
      req_metric      <= metric;
      if (op == dvru_pkg::OP_INSTALL) begin
         installed[idx] = 1'b1;
         installs++;
      end else
         updates++;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Register write: only once every result so far has come back, so the block
   // is idle (each item yields exactly one result).
   task automatic write_nics(input logic [dvru_pkg::CfgW-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg_writes++;
   endtask

   // Sender bursts: a random run of items, then a random gap.
   task automatic pace(input bit gapless);
      if (!gapless) begin
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
            burst_left = $urandom_range(1, 40);
         end
         burst_left--;
      end
   endtask

   // Metrics lean on small values, where minima compete, and on the area
   // around the unreachable threshold.
   function automatic logic [dvru_pkg::MetricW-1:0] pick_metric();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 5)
         return dvru_pkg::MetricW'($urandom_range(0, 15));
      else if (roll < 7)
         return dvru_pkg::MetricW'($urandom_range(995, 1023));
      else if (roll == 7)
         return dvru_pkg::UNREACH;
      else
         return dvru_pkg::MetricW'($urandom_range(0, 1023));
   endfunction

   // Random item: mostly updates on a hot set of routes; an unseeded route
   // always gets an install first.
   task automatic random_item();
      logic [dvru_pkg::IdxW-1:0] idx;
      dvru_pkg::op_type          op;
      if ($urandom_range(0, 9) < 6)
         idx = dvru_pkg::IdxW'($urandom_range(0, 7));
      else
         idx = dvru_pkg::IdxW'($urandom_range(0, ROUTES - 1));
      if (!installed[idx] || $urandom_range(0, 99) < 10)
         op = dvru_pkg::OP_INSTALL;
      else
         op = dvru_pkg::OP_UPDATE;
      send_item(op, idx, dvru_pkg::NicW'($urandom_range(0, NICS - 1)), pick_metric());
   endtask

   // Receiver: changes pacing mode every so often (always ready, coin toss,
   // fixed on/off pattern), and twice holds off for a long stretch so that the
   // block backs up into its input.
   initial begin : receiver
      rx_mode_type mode;
      int mode_left;
      int hold_left;
      int next_hold;
      int period;
      int on_len;
      int tick;
      mode      = RX_ALWAYS;
      mode_left = 0;
      hold_left = 0;
      next_hold = 400;
      period    = 2;
      on_len    = 1;
      tick      = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) results_taken++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (results_taken >= next_hold && long_holds < 2) begin
            hold_left  = HOLD_CYCLES - 1;
            next_hold += 700;
            long_holds++;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = rx_mode_type'($urandom_range(0, 2));
               mode_left = $urandom_range(20, 200);
               period    = $urandom_range(2, 9);
               on_len    = $urandom_range(1, period - 1);
               tick      = 0;
            end
            mode_left--;
            case (mode)
               RX_ALWAYS: rsp_ready <= 1'b1;
               RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               default: begin
                  rsp_ready <= (tick % period) < on_len;
                  tick++;
               end
            endcase
         end
      end
   end

   initial begin : stimulus
      logic [dvru_pkg::CfgW-1:0] plan [7];
      bit gapless;
      installs      = 0;
      updates       = 0;
      cfg_writes    = 0;
      burst_left    = 0;
      foreach (installed[i]) installed[i] = 1'b0;
      // extremes first, then values outside 1..NICS, then 2, then random
      plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2,
               dvru_pkg::CfgW'($urandom_range(0, 15)),
               dvru_pkg::CfgW'($urandom_range(0, 15))};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, register at its reset value (all eight interfaces).
      send_item(dvru_pkg::OP_INSTALL, 6'd0, 3'd0, 10'd0);     // smallest metric
      send_item(dvru_pkg::OP_UPDATE, 6'd0, 3'd7, 10'd0);      // tie: earlier interface kept
      send_item(dvru_pkg::OP_UPDATE, 6'd0, 3'd0, 10'd1023);   // best moves to last interface
      send_item(dvru_pkg::OP_UPDATE, 6'd0, 3'd7, 10'd1000);   // all unreachable: first minimum
      send_item(dvru_pkg::OP_UPDATE, 6'd0, 3'd3, 10'd999);    // 999 + 1 lands on unreachable
      send_item(dvru_pkg::OP_UPDATE, 6'd0, 3'd3, 10'd998);    // just reachable
      send_item(dvru_pkg::OP_INSTALL, 6'd63, 3'd7, 10'd1023); // install saturates
      send_item(dvru_pkg::OP_INSTALL, 6'd62, 3'd3, 10'd999);
      send_item(dvru_pkg::OP_INSTALL, 6'd61, 3'd5, 10'd998);
      send_item(dvru_pkg::OP_UPDATE, 6'd63, 3'd7, 10'd1022);  // stored above threshold
      send_item(dvru_pkg::OP_UPDATE, 6'd63, 3'd0, 10'd1023);
      send_item(dvru_pkg::OP_INSTALL, 6'd1, 3'd2, 10'd500);
      send_item(dvru_pkg::OP_UPDATE, 6'd1, 3'd2, 10'd500);    // nothing changes
      send_item(dvru_pkg::OP_UPDATE, 6'd1, 3'd6, 10'd10);
      send_item(dvru_pkg::OP_UPDATE, 6'd1, 3'd4, 10'd10);     // equal metric, lower interface
      send_item(dvru_pkg::OP_UPDATE, 6'd1, 3'd4, 10'd11);
      send_item(dvru_pkg::OP_INSTALL, 6'd0, 3'd1, 10'd0);     // re-install over live route
      send_item(dvru_pkg::OP_UPDATE, 6'd61, 3'd5, 10'h2aa);
      send_item(dvru_pkg::OP_UPDATE, 6'd61, 3'd2, 10'h155);
      send_item(dvru_pkg::OP_INSTALL, 6'd42, 3'd6, 10'd1000);
      send_item(dvru_pkg::OP_UPDATE, 6'd42, 3'd6, 10'd1000);

      // Random phases, one interface count each.
      foreach (plan[p]) begin
         write_nics(plan[p]);
         gapless    = ($urandom_range(0, 3) == 0);
         burst_left = 0;
         repeat (PHASE_ITEMS) begin
            pace(gapless);
            random_item();
         end
      end

      // Drain, then allow the block's latency once more for stray results.
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("Covered %0d items (%0d installs, %0d updates) under %0d interface-count writes,",
               installs + updates, installs, updates, cfg_writes);
      $display("with %0d results taken and %0d long receiver hold-offs.",
               results_taken, long_holds);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[files.f]
sv/dvru_pkg.sv
sv/dvru_front.sv
sv/dvru_queue.sv
sv/dvru_back.sv
sv/distance_vector_route_update.sv
tb/dvru_route_checker.sv
tb/tb_distance_vector_route_update.sv
